// File: rtl/cic_pkg.sv
// Shared types, codes and constants for the charge inhibit controller.
`default_nettype none

package cic_pkg;

    // Field widths.
    localparam int TimeW  = 32;
    localparam int LimitW = 17;
    localparam int TempW  = 11;
    localparam int PctW   = 7;
    localparam int CfgW   = 17;
    localparam int CfgIdxW = 2;

    // Percent at which the battery counts as full.
    localparam logic [PctW-1:0] PctFull = 7'd100;

    // Register reset values.
    localparam logic signed [TempW-1:0] HighRecoverReset = 11'sd420;
    localparam logic signed [TempW-1:0] LowRecoverReset  = 11'sd20;
    localparam logic [LimitW-1:0] ChargeLimitReset   = 17'd21600;
    localparam logic [LimitW-1:0] RechargeLimitReset = 17'd5400;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_HIGH_RECOVER   = 2'd0,
        CFG_LOW_RECOVER    = 2'd1,
        CFG_CHARGE_LIMIT   = 2'd2,
        CFG_RECHARGE_LIMIT = 2'd3
    } cfg_index_t;

    // Battery health codes.
    typedef enum logic [1:0] {
        HEALTH_GOOD     = 2'd0,
        HEALTH_OVERHEAT = 2'd1,
        HEALTH_COLD     = 2'd2,
        HEALTH_OTHER    = 2'd3
    } health_t;

    // Charger status codes.
    typedef enum logic [1:0] {
        STATUS_DISCHARGING  = 2'd0,
        STATUS_CHARGING     = 2'd1,
        STATUS_NOT_CHARGING = 2'd2,
        STATUS_FULL         = 2'd3
    } status_t;

    // Inhibit reason bit positions.
    localparam int ReasonFull     = 0;
    localparam int ReasonOverheat = 1;
    localparam int ReasonFreeze   = 2;
    localparam int ReasonOvertime = 3;

    // One poll beat as held in the input register.
    typedef struct packed {
        logic                    supply_present;
        logic [TimeW-1:0]        now_seconds;
        logic [PctW-1:0]         charge_percent;
        logic signed [TempW-1:0] battery_temp;
        logic [1:0]              health_code;
        logic                    cable_is_ac;
        logic                    full_event;
    } poll_t;

    // One result beat as held in the output register.
    typedef struct packed {
        logic       charge_enable;
        logic       ac_profile;
        logic [1:0] charge_status;
        logic [3:0] inhibit_reasons;
        logic       usb_hold;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/cic_poll_if.sv
// Poll channel: valid/ready handshake with the poll fields.
`default_nettype none

interface cic_poll_if
    import cic_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    supply_present;
    logic [TimeW-1:0]        now_seconds;
    logic [PctW-1:0]         charge_percent;
    logic signed [TempW-1:0] battery_temp;
    logic [1:0]              health_code;
    logic                    cable_is_ac;
    logic                    full_event;

    modport source (
        output valid, supply_present, now_seconds, charge_percent, battery_temp,
               health_code, cable_is_ac, full_event,
        input  ready
    );

    modport sink (
        input  valid, supply_present, now_seconds, charge_percent, battery_temp,
               health_code, cable_is_ac, full_event,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/cic_result_if.sv
// Result channel: valid/ready handshake with the result fields.
`default_nettype none

interface cic_result_if;
    logic       valid;
    logic       ready;
    logic       charge_enable;
    logic       ac_profile;
    logic [1:0] charge_status;
    logic [3:0] inhibit_reasons;
    logic       usb_hold;

    modport source (
        output valid, charge_enable, ac_profile, charge_status, inhibit_reasons,
               usb_hold,
        input  ready
    );

    modport sink (
        input  valid, charge_enable, ac_profile, charge_status, inhibit_reasons,
               usb_hold,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/charge_inhibit_controller_unit.sv
// Top level of the charge inhibit controller: safety timer and inhibit logic.
//
//   Channel   Dir  Handshake           Beat
//   poll      in   valid/ready         one poll of supply, time and battery readings
//   result    out  valid/ready         charger enable, profile, status and reasons
//   cfg       in   cfg_write_en        one register write, no wait
//
// A poll beat lands in the input register, is evaluated by combinational logic
// and lands in the result register, so one beat per cycle flows through while
// the result is not stalled. The 33-bit deadline add and compare set the
// critical path. Reset clears all flags, the deadline and both valid bits and
// loads the register defaults. A stalled result holds the pipeline; the input
// register still takes a beat while it is empty.
`default_nettype none

module charge_inhibit_controller_unit
    import cic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    cic_poll_if.sink                poll,
    cic_result_if.source            result,
    input  wire logic               cfg_write_en,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [CfgW-1:0]    cfg_data
);

    // Configuration registers.
    logic signed [TempW-1:0] high_recover_reg;
    logic signed [TempW-1:0] low_recover_reg;
    logic [LimitW-1:0]       charge_limit_reg;
    logic [LimitW-1:0]       recharge_limit_reg;

    // Pipeline registers.
    logic    in_valid_reg;
    poll_t   in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;

    // Controller state.
    logic [3:0]       reason_reg, reason_next;
    logic             full_latched_reg, full_latched_next;
    logic             battery_full_reg, battery_full_next;
    logic             timeout_seen_reg, timeout_seen_next;
    logic [TimeW-1:0] deadline_reg, deadline_next;
    result_t          result_next;

    // Evaluation temporaries.
    logic              pct_full;
    logic              full_now;
    logic              expired;
    logic [LimitW-1:0] limit;
    logic [TimeW:0]    deadline_sum;
    status_t           status;

    // Handshake: the evaluation stage moves when the result register frees up.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !in_valid_reg || advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_recover_reg   <= HighRecoverReset;
            low_recover_reg    <= LowRecoverReset;
            charge_limit_reg   <= ChargeLimitReset;
            recharge_limit_reg <= RechargeLimitReset;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HIGH_RECOVER:   high_recover_reg   <= cfg_data[TempW-1:0];
                CFG_LOW_RECOVER:    low_recover_reg    <= cfg_data[TempW-1:0];
                CFG_CHARGE_LIMIT:   charge_limit_reg   <= cfg_data[LimitW-1:0];
                CFG_RECHARGE_LIMIT: recharge_limit_reg <= cfg_data[LimitW-1:0];
                default:            high_recover_reg   <= high_recover_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            in_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.ready && poll.valid)
        begin
            in_reg.supply_present <= poll.supply_present;
            in_reg.now_seconds    <= poll.now_seconds;
            in_reg.charge_percent <= poll.charge_percent;
            in_reg.battery_temp   <= poll.battery_temp;
            in_reg.health_code    <= poll.health_code;
            in_reg.cable_is_ac    <= poll.cable_is_ac;
            in_reg.full_event     <= poll.full_event;
        end
    end

    // Evaluate one poll: full mark, then reasons, then supply and charger.
    always_comb
    begin
        pct_full = (in_reg.charge_percent >= PctFull);
        full_now = in_reg.full_event || pct_full;

        full_latched_next = full_latched_reg || full_now;
        battery_full_next = battery_full_reg || full_now;

        // Hysteresis clears on the reasons pending before this poll.
        reason_next = reason_reg;
        if (reason_reg[ReasonFull] && !pct_full)
        begin
            reason_next[ReasonFull] = 1'b0;
        end
        if (reason_reg[ReasonOverheat] && (in_reg.battery_temp <= high_recover_reg))
        begin
            reason_next[ReasonOverheat] = 1'b0;
        end
        if (reason_reg[ReasonFreeze] && (in_reg.battery_temp >= low_recover_reg))
        begin
            reason_next[ReasonFreeze] = 1'b0;
        end
        if (reason_reg[ReasonOvertime] && !pct_full)
        begin
            reason_next[ReasonOvertime] = 1'b0;
        end

        // New reasons.
        if (full_latched_next)
        begin
            reason_next[ReasonFull] = 1'b1;
        end
        case (health_t'(in_reg.health_code))
            HEALTH_GOOD:     reason_next = reason_next;
            HEALTH_OVERHEAT: reason_next[ReasonOverheat] = 1'b1;
            default:         reason_next[ReasonFreeze] = 1'b1;
        endcase

        expired = (deadline_reg != '0) && (in_reg.now_seconds > deadline_reg);
        timeout_seen_next = timeout_seen_reg || expired;
        if (expired)
        begin
            reason_next[ReasonOvertime] = 1'b1;
        end

        // A recharge after full or timeout gets the recharge limit.
        limit = (battery_full_next || timeout_seen_next) ? recharge_limit_reg
                                                          : charge_limit_reg;
        deadline_sum = {1'b0, in_reg.now_seconds} + {{(TimeW + 1 - LimitW){1'b0}}, limit};

        deadline_next = deadline_reg;
        result_next.charge_enable = 1'b0;
        status = STATUS_DISCHARGING;

        if (in_reg.supply_present)
        begin
            if (reason_next != '0)
            begin
                status            = battery_full_next ? STATUS_FULL : STATUS_NOT_CHARGING;
                deadline_next     = '0;
                full_latched_next = 1'b0;
            end
            else
            begin
                // Arm the deadline, saturating on overflow.
                if (deadline_reg == '0)
                begin
                    deadline_next = deadline_sum[TimeW] ? {TimeW{1'b1}}
                                                        : deadline_sum[TimeW-1:0];
                end
                result_next.charge_enable = 1'b1;
                status = battery_full_next ? STATUS_FULL : STATUS_CHARGING;
            end
        end
        else
        begin
            // Supply removed: start over.
            battery_full_next = 1'b0;
            timeout_seen_next = 1'b0;
            full_latched_next = 1'b0;
            reason_next       = '0;
            deadline_next     = '0;
        end

        result_next.ac_profile      = result_next.charge_enable && in_reg.cable_is_ac;
        result_next.charge_status   = status;
        result_next.inhibit_reasons = reason_next;
        result_next.usb_hold        = in_reg.supply_present && !in_reg.cable_is_ac;
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reason_reg       <= '0;
            full_latched_reg <= 1'b0;
            battery_full_reg <= 1'b0;
            timeout_seen_reg <= 1'b0;
            deadline_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                reason_reg       <= reason_next;
                full_latched_reg <= full_latched_next;
                battery_full_reg <= battery_full_next;
                timeout_seen_reg <= timeout_seen_next;
                deadline_reg     <= deadline_next;
                out_valid_reg    <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    // Result channel.
    assign result.valid           = out_valid_reg;
    assign result.charge_enable   = out_reg.charge_enable;
    assign result.ac_profile      = out_reg.ac_profile;
    assign result.charge_status   = out_reg.charge_status;
    assign result.inhibit_reasons = out_reg.inhibit_reasons;
    assign result.usb_hold        = out_reg.usb_hold;

endmodule

`default_nettype wire

// File: tb/tb_charge_inhibit_controller_unit.sv
// Self-checking testbench for the charge inhibit controller unit.
`timescale 1ns / 100ps

module tb_charge_inhibit_controller_unit;
    import cic_pkg::*;

    // Run limit in clock cycles; the slowest legal run needs well under half of it.
    localparam int CycleLimit = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    cfg_index_t cfg_index;
    logic [CfgW-1:0] cfg_data;

    cic_poll_if   poll_ch ();
    cic_result_if result_ch ();

    charge_inhibit_controller_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll         (poll_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predicted register contents.
    logic signed [TempW-1:0] overheat_clear_temp;
    logic signed [TempW-1:0] freeze_clear_temp;
    logic [LimitW-1:0]       first_charge_limit;
    logic [LimitW-1:0]       recharge_limit;

    // Predicted controller state.
    logic [3:0]       inhibit_flags;
    logic             full_pending;
    logic             seen_full;
    logic             timer_expired;
    logic [TimeW-1:0] charge_deadline;
    logic             charger_on;

    // Charger responses waiting for their result beat.
    result_t pending_responses[$];
    int      mismatch_count;
    int      cycle_count;

    // Idling controls for the sender and the receiver.
    bit src_idle_on;
    bit sink_idle_on;
    int hold_request;

    // Running values of the simulated charge session.
    logic [TimeW-1:0] sess_now;
    int               sess_pct;
    int               sess_temp;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Cycle counter guarding against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Works out the charger response to one poll and advances the predicted state.
    function automatic result_t predict_charger_response(input poll_t p);
        result_t                 r;
        logic [PctW-1:0]         pct;
        logic signed [TempW-1:0] temp;
        logic [3:0]              held;
        logic [LimitW-1:0]       lim;
        logic [TimeW:0]          sum;
        status_t                 st;
        pct  = (p.charge_percent > PctFull) ? PctFull : p.charge_percent;
        temp = p.battery_temp;

        // A full event or a full reading marks the battery full.
        if (p.full_event || pct >= PctFull)
        begin
            full_pending = 1'b1;
            seen_full    = 1'b1;
        end

        // Reasons pending before this poll clear with hysteresis.
        held = inhibit_flags;
        if (held[ReasonFull] && pct < PctFull)
            inhibit_flags[ReasonFull] = 1'b0;
        if (held[ReasonOverheat] && temp <= overheat_clear_temp)
            inhibit_flags[ReasonOverheat] = 1'b0;
        if (held[ReasonFreeze] && temp >= freeze_clear_temp)
            inhibit_flags[ReasonFreeze] = 1'b0;
        if (held[ReasonOvertime] && pct < PctFull)
            inhibit_flags[ReasonOvertime] = 1'b0;

        // New reasons from the full mark, health and the safety timer.
        if (full_pending)
            inhibit_flags[ReasonFull] = 1'b1;
        if (health_t'(p.health_code) == HEALTH_OVERHEAT)
            inhibit_flags[ReasonOverheat] = 1'b1;
        else if (health_t'(p.health_code) != HEALTH_GOOD)
            inhibit_flags[ReasonFreeze] = 1'b1;
        if (charge_deadline != '0 && p.now_seconds > charge_deadline)
        begin
            timer_expired = 1'b1;
            inhibit_flags[ReasonOvertime] = 1'b1;
        end

        // Supply and charger update.
        if (p.supply_present)
        begin
            if (inhibit_flags != '0)
            begin
                charger_on      = 1'b0;
                st              = seen_full ? STATUS_FULL : STATUS_NOT_CHARGING;
                charge_deadline = '0;
                full_pending    = 1'b0;
            end
            else
            begin
                if (charge_deadline == '0)
                begin
                    lim = (seen_full || timer_expired) ? recharge_limit : first_charge_limit;
                    sum = {1'b0, p.now_seconds} + {16'd0, lim};
                    charge_deadline = sum[TimeW] ? '1 : sum[TimeW-1:0];
                end
                charger_on = 1'b1;
                st         = seen_full ? STATUS_FULL : STATUS_CHARGING;
            end
        end
        else
        begin
            charger_on      = 1'b0;
            st              = STATUS_DISCHARGING;
            seen_full       = 1'b0;
            timer_expired   = 1'b0;
            full_pending    = 1'b0;
            inhibit_flags   = '0;
            charge_deadline = '0;
        end

        r.charge_enable   = charger_on;
        r.ac_profile      = charger_on && p.cable_is_ac;
        r.charge_status   = st;
        r.inhibit_reasons = inhibit_flags;
        r.usb_hold        = p.supply_present && !p.cable_is_ac;
        return r;
    endfunction

    function automatic poll_t make_poll(input int supply, input logic [TimeW-1:0] now,
                                        input int pct, input int temp, input health_t health,
                                        input int is_ac, input int full_ev);
        poll_t p;
        p.supply_present = supply[0];
        p.now_seconds    = now;
        p.charge_percent = pct[PctW-1:0];
        p.battery_temp   = temp[TempW-1:0];
        p.health_code    = health;
        p.cable_is_ac    = is_ac[0];
        p.full_event     = full_ev[0];
        return p;
    endfunction

    // Next poll of a plausible charge session, with some raw noise mixed in.
    function automatic poll_t next_session_poll();
        poll_t p;
        int    r;
        int    lim;
        if ($urandom_range(0, 99) < 12)
        begin
            p = make_poll($urandom_range(0, 1), $urandom, $urandom_range(0, 127),
                          $urandom_range(0, 2047), health_t'($urandom_range(0, 3)),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            return p;
        end

        // Time mostly creeps, sometimes jumps past the deadline or near the wrap.
        lim = ($urandom_range(0, 1) != 0) ? int'(first_charge_limit) : int'(recharge_limit);
        r = $urandom_range(0, 99);
        if (r < 70)
            sess_now = sess_now + $urandom_range(0, 3);
        else if (r < 85)
            sess_now = sess_now + $urandom_range(0, lim / 2 + 1);
        else if (r < 97)
            sess_now = sess_now + lim + $urandom_range(0, 3) - 1;
        else
            sess_now = 32'hFFFF_FFFF - $urandom_range(0, 200);

        // Percent drifts, sometimes sits near full or reads above it.
        r = $urandom_range(0, 99);
        sess_pct = sess_pct + $urandom_range(0, 6) - 2;
        if (sess_pct < 0)
            sess_pct = 0;
        if (sess_pct > 100)
            sess_pct = 100;
        if (r >= 85 && r < 95)
            sess_pct = $urandom_range(95, 100);
        p.charge_percent = PctW'((r >= 95) ? $urandom_range(101, 127) : sess_pct);

        // Temperature hovers, often right at one of the recovery thresholds.
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            sess_temp = sess_temp + $urandom_range(0, 20) - 10;
            if (sess_temp < -400)
                sess_temp = -400;
            if (sess_temp > 1000)
                sess_temp = 1000;
            p.battery_temp = TempW'(sess_temp);
        end
        else if (r < 65)
            p.battery_temp = TempW'(int'(overheat_clear_temp) + $urandom_range(0, 4) - 2);
        else if (r < 90)
            p.battery_temp = TempW'(int'(freeze_clear_temp) + $urandom_range(0, 4) - 2);
        else
            p.battery_temp = TempW'($urandom_range(0, 2047));

        r = $urandom_range(0, 99);
        if (r < 80)
            p.health_code = HEALTH_GOOD;
        else if (r < 88)
            p.health_code = HEALTH_OVERHEAT;
        else if (r < 94)
            p.health_code = HEALTH_COLD;
        else
            p.health_code = HEALTH_OTHER;

        p.supply_present = ($urandom_range(0, 99) < 96);
        p.now_seconds    = sess_now;
        p.cable_is_ac    = 1'($urandom_range(0, 1));
        p.full_event     = ($urandom_range(0, 99) < 4);
        return p;
    endfunction

    // Offers one poll beat and predicts its response once it is taken.
    task automatic send_poll(input poll_t p);
        int gap;
        poll_ch.valid          <= 1'b1;
        poll_ch.supply_present <= p.supply_present;
        poll_ch.now_seconds    <= p.now_seconds;
        poll_ch.charge_percent <= p.charge_percent;
        poll_ch.battery_temp   <= p.battery_temp;
        poll_ch.health_code    <= p.health_code;
        poll_ch.cable_is_ac    <= p.cable_is_ac;
        poll_ch.full_event     <= p.full_event;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        pending_responses.push_back(predict_charger_response(p));
        @(negedge clk);
        gap = src_idle_on ? idle_len() : 0;
        if (gap > 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stops offering polls and lets the pipeline drain.
    task automatic wait_idle();
        poll_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes all four registers on consecutive cycles.
    task automatic program_registers(input int hi, input int lo, input int chg, input int rchg);
        logic [CfgW-1:0] vals[4];
        vals[CFG_HIGH_RECOVER]   = hi[CfgW-1:0];
        vals[CFG_LOW_RECOVER]    = lo[CfgW-1:0];
        vals[CFG_CHARGE_LIMIT]   = chg[CfgW-1:0];
        vals[CFG_RECHARGE_LIMIT] = rchg[CfgW-1:0];
        cfg_write_en <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            @(negedge clk);
        end
        cfg_write_en <= 1'b0;
        overheat_clear_temp = hi[TempW-1:0];
        freeze_clear_temp   = lo[TempW-1:0];
        first_charge_limit  = chg[LimitW-1:0];
        recharge_limit      = rchg[LimitW-1:0];
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker: every result beat against the oldest predicted response.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("result beat with no poll outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("charge_enable", int'(want.charge_enable),
                            int'(result_ch.charge_enable));
                check_field("ac_profile", int'(want.ac_profile), int'(result_ch.ac_profile));
                check_field("charge_status", int'(want.charge_status),
                            int'(result_ch.charge_status));
                check_field("inhibit_reasons", int'(want.inhibit_reasons),
                            int'(result_ch.inhibit_reasons));
                check_field("usb_hold", int'(want.usb_hold), int'(result_ch.usb_hold));
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 99) < 20)
                    stall_left = idle_len();
            end
        end
    end

    // Extremes of every field, each health code, full handling and timer edges.
    task automatic test_directed_cases();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_poll(make_poll(0, 0, 0, 0, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 0, 50, 250, HEALTH_GOOD, 1, 0));
        // Deadline reached exactly, then passed by one second.
        send_poll(make_poll(1, 21600, 50, 250, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 21601, 50, 250, HEALTH_GOOD, 0, 0));
        // Full reading, drop below full, then percent above full.
        send_poll(make_poll(1, 21602, 100, 250, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 21603, 99, 250, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 21604, 127, 250, HEALTH_GOOD, 1, 0));
        // Overheat and its recovery threshold.
        send_poll(make_poll(1, 21605, 50, 1023, HEALTH_OVERHEAT, 1, 0));
        send_poll(make_poll(1, 21606, 50, 421, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 21607, 50, 420, HEALTH_GOOD, 1, 0));
        // Freeze and its recovery threshold.
        send_poll(make_poll(1, 21608, 50, -1024, HEALTH_COLD, 1, 0));
        send_poll(make_poll(1, 21609, 50, 19, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 21610, 50, 20, HEALTH_GOOD, 1, 0));
        // The unused health code counts as a cold fault.
        send_poll(make_poll(1, 21611, 50, 1000, HEALTH_OTHER, 1, 0));
        send_poll(make_poll(1, 21612, 0, -400, HEALTH_GOOD, 0, 0));
        send_poll(make_poll(0, 21613, 0, 0, HEALTH_GOOD, 0, 1));
        // Deadline saturates near the top of time and never expires.
        send_poll(make_poll(1, 32'hFFFF_FF00, 10, 250, HEALTH_GOOD, 0, 0));
        send_poll(make_poll(1, 32'hFFFF_FFFF, 10, 250, HEALTH_GOOD, 0, 0));
        send_poll(make_poll(1, 32'hFFFF_FFFF, 10, 250, HEALTH_GOOD, 1, 1));
        send_poll(make_poll(0, 0, 0, 0, HEALTH_GOOD, 0, 0));
    endtask

    // A zero charge limit at time zero leaves no deadline until the clock moves.
    task automatic test_zero_limit_deadline();
        wait_idle();
        program_registers(420, 20, 0, 'h1FFFF);
        send_poll(make_poll(1, 0, 30, 250, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 0, 30, 250, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 1, 30, 250, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 2, 30, 250, HEALTH_GOOD, 1, 0));
        send_poll(make_poll(1, 3, 40, 250, HEALTH_GOOD, 1, 0));
    endtask

    // Long receiver hold-off while polls keep coming, then a full drain.
    task automatic test_output_backpressure();
        wait_idle();
        program_registers(420, 20, 40, 15);
        sess_now  = 100;
        sess_pct  = 30;
        sess_temp = 250;
        src_idle_on  = 1'b0;
        hold_request = 150;
        repeat (16) send_poll(next_session_poll());
        wait_idle();
    endtask

    // Random charge sessions under one register setting.
    task automatic test_session_traffic(input int hi, input int lo, input int chg,
                                        input int rchg, input int n_items);
        wait_idle();
        program_registers(hi, lo, chg, rchg);
        sess_now  = $urandom_range(0, 1000);
        sess_pct  = $urandom_range(0, 100);
        sess_temp = 250;
        for (int i = 0; i < n_items; i++)
        begin
            // The first part of each phase runs back to back on both sides.
            src_idle_on  = (i >= n_items / 6);
            sink_idle_on = (i >= n_items / 6);
            send_poll(next_session_poll());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = CFG_HIGH_RECOVER;
        cfg_data       = '0;
        poll_ch.valid          = 1'b0;
        poll_ch.supply_present = 1'b0;
        poll_ch.now_seconds    = '0;
        poll_ch.charge_percent = '0;
        poll_ch.battery_temp   = '0;
        poll_ch.health_code    = HEALTH_GOOD;
        poll_ch.cable_is_ac    = 1'b0;
        poll_ch.full_event     = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_request   = 0;
        src_idle_on    = 1'b0;
        sink_idle_on   = 1'b0;

        // Predictor starts from the reset state.
        overheat_clear_temp = HighRecoverReset;
        freeze_clear_temp   = LowRecoverReset;
        first_charge_limit  = ChargeLimitReset;
        recharge_limit      = RechargeLimitReset;
        inhibit_flags   = '0;
        full_pending    = 1'b0;
        seen_full       = 1'b0;
        timer_expired   = 1'b0;
        charge_deadline = '0;
        charger_on      = 1'b0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_zero_limit_deadline();
        test_output_backpressure();
        test_session_traffic(420, 20, 60, 25, 480);
        test_session_traffic(1000, -400, 1, 86400, 470);
        test_session_traffic('h1FFFF, 'h3FF, 'h1FFFF, 0, 470);
        test_session_traffic($urandom_range(0, 131071), $urandom_range(0, 131071),
                             $urandom_range(1, 300), $urandom_range(1, 300), 470);

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
